// ===== sv/aeske_pkg.sv =====
package aeske_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned GROUP_W  = 4 * WORD_W;
	localparam int unsigned PART_W   = 64;
	localparam int unsigned ROUND_W  = 4;

	localparam logic [ROUND_W-1:0] FIRST_ROUND = 4'd0;
	localparam logic [ROUND_W-1:0] LAST_ROUND  = 4'd14;

	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [GROUP_W-1:0] group_t;
	typedef logic [ROUND_W-1:0] round_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
		8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
		8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
		8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
		8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
		8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
		8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
		8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
		8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
		8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
		8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
		8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
		8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
		8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
		8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
		8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
		8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] RCON [8] = '{
		8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40
	};

	function automatic word_t sub_word(input word_t w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	function automatic word_t rotate_word(input word_t w);
		rotate_word = {w[23:0], w[31:24]};
	endfunction

endpackage

// ===== sv/aeske_key_if.sv =====
interface aeske_key_if;
	logic                             valid;
	logic                             ready;
	logic [aeske_pkg::PART_W-1:0]     key_part_0;
	logic [aeske_pkg::PART_W-1:0]     key_part_1;
	logic [aeske_pkg::PART_W-1:0]     key_part_2;
	logic [aeske_pkg::PART_W-1:0]     key_part_3;

	modport source (
		output valid, key_part_0, key_part_1, key_part_2, key_part_3,
		input  ready
	);
	modport sink (
		input  valid, key_part_0, key_part_1, key_part_2, key_part_3,
		output ready
	);
endinterface

// ===== sv/aeske_rkey_if.sv =====
interface aeske_rkey_if;
	logic                             valid;
	logic                             ready;
	logic [aeske_pkg::PART_W-1:0]     round_key_high;
	logic [aeske_pkg::PART_W-1:0]     round_key_low;
	logic [aeske_pkg::ROUND_W-1:0]    round_number;
	logic                             last_key;

	modport source (
		output valid, round_key_high, round_key_low, round_number, last_key,
		input  ready
	);
	modport sink (
		input  valid, round_key_high, round_key_low, round_number, last_key,
		output ready
	);
endinterface

// ===== sv/aeske_cell.sv =====
module aeske_cell (
	input  logic                 clk,
	input  aeske_pkg::cell_ctl_t ctl,
	input  aeske_pkg::group_t    load_data,
	input  aeske_pkg::group_t    shift_data,
	output aeske_pkg::group_t    group
);

	aeske_pkg::group_t group_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			group_q <= load_data;
		end else if (ctl.shift) begin
			group_q <= shift_data;
		end
	end

	assign group = group_q;

endmodule

// ===== sv/aeske_step.sv =====
module aeske_step (
	input  aeske_pkg::group_t older,
	input  aeske_pkg::group_t newer,
	input  aeske_pkg::round_t round,
	output aeske_pkg::group_t next
);

	logic [aeske_pkg::ROUND_W:0] grp_idx;
	aeske_pkg::word_t            prev_w;
	aeske_pkg::word_t            t;
	aeske_pkg::word_t            x0, x1, x2, x3;

	// group being built is round + 2; even groups start a key-length block
	assign grp_idx = {1'b0, round} + 5'd2;
	assign prev_w  = newer[aeske_pkg::WORD_W-1:0];

	always_comb begin
		if (!round[0]) begin
			t = aeske_pkg::sub_word(aeske_pkg::rotate_word(prev_w))
				^ {aeske_pkg::RCON[grp_idx[3:1]], 24'h000000};
		end else begin
			t = aeske_pkg::sub_word(prev_w);
		end
	end

	assign x0 = t  ^ older[127:96];
	assign x1 = x0 ^ older[95:64];
	assign x2 = x1 ^ older[63:32];
	assign x3 = x2 ^ older[31:0];

	assign next = {x0, x1, x2, x3};

endmodule

// ===== sv/aes256_key_expansion.sv =====
// AES-256 key schedule. A key transaction on key_in yields fifteen round-key
// transactions on rkey, rounds 0 to 14 in order, last_key marking round 14.
// One round key leaves per cycle when rkey.ready stays high; the next key is
// taken in the same cycle the round-14 key is accepted. The rate is set by two
// 128-bit cells holding the current and next round key and by one step unit
// that builds the following four schedule words (one S-box word, a four-deep
// XOR chain) per output transaction.
module aes256_key_expansion (
	input  logic          clk,
	input  logic          arst_n,
	aeske_key_if.sink     key_in,
	aeske_rkey_if.source  rkey
);

	logic                 busy_q;
	aeske_pkg::round_t    round_q;
	logic                 in_acc;
	logic                 out_acc;
	logic                 at_last;
	aeske_pkg::cell_ctl_t ctl;
	aeske_pkg::group_t    cur_grp;
	aeske_pkg::group_t    nxt_grp;
	aeske_pkg::group_t    step_grp;

	assign at_last      = (round_q == aeske_pkg::LAST_ROUND);
	assign key_in.ready = !busy_q || (rkey.ready && at_last);
	assign in_acc       = key_in.valid && key_in.ready;
	assign out_acc      = rkey.valid && rkey.ready;

	assign ctl.load  = in_acc;
	assign ctl.shift = out_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			round_q <= aeske_pkg::FIRST_ROUND;
		end else if (in_acc) begin
			busy_q  <= 1'b1;
			round_q <= aeske_pkg::FIRST_ROUND;
		end else if (out_acc) begin
			busy_q  <= !at_last;
			round_q <= round_q + 4'd1;
		end
	end

	aeske_cell u_cell_cur (
		.clk        (clk),
		.ctl        (ctl),
		.load_data  ({key_in.key_part_0, key_in.key_part_1}),
		.shift_data (nxt_grp),
		.group      (cur_grp)
	);

	aeske_cell u_cell_nxt (
		.clk        (clk),
		.ctl        (ctl),
		.load_data  ({key_in.key_part_2, key_in.key_part_3}),
		.shift_data (step_grp),
		.group      (nxt_grp)
	);

	aeske_step u_step (
		.older (cur_grp),
		.newer (nxt_grp),
		.round (round_q),
		.next  (step_grp)
	);

	assign rkey.valid          = busy_q;
	assign rkey.round_key_high = cur_grp[127:64];
	assign rkey.round_key_low  = cur_grp[63:0];
	assign rkey.round_number   = round_q;
	assign rkey.last_key       = at_last;

endmodule

// ===== sv/aeske_checker.sv =====
module aeske_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [aeske_pkg::PART_W-1:0]  out_high,
	input logic [aeske_pkg::ROUND_W-1:0] out_round,
	input logic                          out_last
);

	// stalled output transaction holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_high) && $stable(out_round))
		else $error("round key changed while stalled");

	// a new key starts at round 0
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid && out_round == aeske_pkg::FIRST_ROUND)
		else $error("round key run did not start at round 0");

	// rounds advance by one within a run
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid && out_round == $past(out_round) + 4'd1)
		else $error("round number skipped");

	// last flag only on round 14
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_last == (out_round == aeske_pkg::LAST_ROUND))
		else $error("last_key does not match round 14");

	// no key taken mid-run
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !(out_ready && out_last) |-> !in_ready)
		else $error("key accepted before run finished");

endmodule

bind aes256_key_expansion aeske_checker u_aeske_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (key_in.valid),
	.in_ready  (key_in.ready),
	.out_valid (rkey.valid),
	.out_ready (rkey.ready),
	.out_high  (rkey.round_key_high),
	.out_round (rkey.round_number),
	.out_last  (rkey.last_key)
);
